/* src/tcpq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared codes, widths and types for the three-class priority job queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // defaults for the top-level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;

    // number of wait classes and their indexes
    localparam int NUM_CLASSES = 3;
    localparam int CLASS_W     = 2;
    localparam logic [CLASS_W-1:0] CLS_HIGH     = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_ORDINARY = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_LOW      = 2'd2;

    // request types
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SELECT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RETURN = 2'd2;
    localparam logic [REQ_W-1:0] REQ_COMMIT = 2'd3;

    // raw priority codes
    localparam int PRIO_W = 2;
    localparam logic [PRIO_W-1:0] PRIO_HIGH     = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_ORDINARY = 2'd1;
    localparam logic [PRIO_W-1:0] PRIO_LOW      = 2'd2;
    localparam logic [PRIO_W-1:0] PRIO_INVALID  = 2'd3;

    // result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // waiting count output, saturating
    localparam int WAIT_COUNT_W = 6;
    localparam int WAIT_MAX     = 63;

    // per-deque command for one request
    typedef struct packed {
        logic push;
        logic at_head;
        logic pop;
    } deque_cmd_t;

endpackage

/* src/tcpq_deque.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_deque
// One circular wait deque of job ids: insert at head or tail, pop at head.
// ----------------------------------------------------------------------------
module tcpq_deque #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16,
    parameter int CNT_W       = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcpq_pkg::deque_cmd_t cmd,
    input  logic [ID_WIDTH-1:0]  push_data,
    output logic [ID_WIDTH-1:0]  head_data,
    output logic [CNT_W-1:0]     count_next,
    output logic                 full,
    output logic                 empty
);
    import tcpq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [ID_WIDTH-1:0] store_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    head_dec;
    logic [IDX_W-1:0]    head_inc;
    logic [SUM_W-1:0]    tail_sum;
    logic [SUM_W-1:0]    tail_wrap;
    logic [IDX_W-1:0]    wr_idx;

    // neighbor positions around the head, with wrap at the depth
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    // tail slot is head plus count, folded back once
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       tail_sum - SUM_W'(QUEUE_DEPTH) : tail_sum;
    assign wr_idx    = cmd.at_head ? head_dec : tail_wrap[IDX_W-1:0];

    assign head_data = store_reg[head_reg];
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    // pointer and fill updates
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + 1'b1;
            if (cmd.at_head) begin
                head_next = head_dec;
            end
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
            head_next  = head_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            store_reg[wr_idx] <= push_data;
        end
    end

endmodule

/* src/three_class_priority_job_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_class_priority_job_queue
// Strict priority job queue with three wait deques and a staging slot.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready): add, select, return or
//   commit. Each request gives exactly one result on the m_ channel
//   (valid/ready) with status, the job moved, a run strobe for commits and a
//   snapshot of staging, waiting count and per-class empty flags.
//   Each request passes two register stages: request register, result
//   register. Throughput: one request per cycle while the receiver takes
//   results; every request touches at most one deque head or tail and the
//   staging slot in a single pass between those registers.
//   When the receiver stalls, the result register holds and the request
//   register fills, then s_ready drops until the result is taken.
//   Reset (aresetn low, synchronous) empties all deques and staging; deque
//   entries themselves are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module three_class_priority_job_queue #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = tcpq_pkg::DEF_ID_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tcpq_pkg::REQ_W-1:0]        s_req_type,
    input  logic [ID_WIDTH-1:0]               s_job_id,
    input  logic [tcpq_pkg::PRIO_W-1:0]       s_priority_req,
    input  logic                              s_push_front,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tcpq_pkg::STATUS_W-1:0]     m_status,
    output logic [ID_WIDTH-1:0]               m_result_job,
    output logic                              m_run_valid,
    output logic                              m_staging_valid,
    output logic [ID_WIDTH-1:0]               m_staging_job,
    output logic [tcpq_pkg::WAIT_COUNT_W-1:0] m_waiting_count,
    output logic                              m_high_empty,
    output logic                              m_ordinary_empty,
    output logic                              m_low_empty
);
    import tcpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W = CNT_W + 2 + WAIT_COUNT_W;

    // request register
    logic                in_valid_reg;
    logic [REQ_W-1:0]    in_req_reg;
    logic [ID_WIDTH-1:0] in_job_reg;
    logic [PRIO_W-1:0]   in_prio_reg;
    logic                in_front_reg;

    // staging slot
    logic                stg_valid_reg, stg_valid_next;
    logic [ID_WIDTH-1:0] stg_id_reg, stg_id_next;
    logic [CLASS_W-1:0]  stg_class_reg, stg_class_next;

    // result register
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic [ID_WIDTH-1:0]     out_job_reg, out_job_next;
    logic                    out_run_reg, out_run_next;
    logic                    out_stg_valid_reg;
    logic [ID_WIDTH-1:0]     out_stg_job_reg;
    logic [WAIT_COUNT_W-1:0] out_wait_reg, out_wait_next;
    logic [NUM_CLASSES-1:0]  out_empty_reg, out_empty_next;

    // deque interface
    deque_cmd_t          dq_cmd   [NUM_CLASSES];
    logic [ID_WIDTH-1:0] dq_head  [NUM_CLASSES];
    logic [CNT_W-1:0]    dq_count [NUM_CLASSES];
    logic                dq_full  [NUM_CLASSES];
    logic                dq_empty [NUM_CLASSES];
    logic [ID_WIDTH-1:0] push_data;

    logic             fire;
    logic [TOT_W-1:0] total;

    // handshake: process when the result register is free or draining
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg   <= s_req_type;
            in_job_reg   <= s_job_id;
            in_prio_reg  <= s_priority_req;
            in_front_reg <= s_push_front;
        end
    end

    // the three wait deques
    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_deque
        tcpq_deque #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .ID_WIDTH    (ID_WIDTH),
            .CNT_W       (CNT_W)
        ) u_deque (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (dq_cmd[c]),
            .push_data  (push_data),
            .head_data  (dq_head[c]),
            .count_next (dq_count[c]),
            .full       (dq_full[c]),
            .empty      (dq_empty[c])
        );
    end

    assign push_data = (in_req_reg == REQ_ADD) ? in_job_reg : stg_id_reg;

    // request decode and staging update
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            dq_cmd[c] = '0;
        end
        stg_valid_next  = stg_valid_reg;
        stg_id_next     = stg_id_reg;
        stg_class_next  = stg_class_reg;
        out_status_next = ST_OK;
        out_job_next    = '0;
        out_run_next    = 1'b0;
        if (fire) begin
            unique case (in_req_reg)
                REQ_ADD: begin
                    if (in_prio_reg == PRIO_INVALID) begin
                        out_status_next = ST_BAD_PRIO;
                    end else begin
                        out_job_next = in_job_reg;
                        if (dq_full[in_prio_reg]) begin
                            out_status_next = ST_FULL;
                        end else begin
                            dq_cmd[in_prio_reg].push    = 1'b1;
                            dq_cmd[in_prio_reg].at_head = in_front_reg;
                        end
                    end
                end
                REQ_SELECT: begin
                    if (!dq_empty[CLS_HIGH]) begin
                        dq_cmd[CLS_HIGH].pop = 1'b1;
                        out_job_next         = dq_head[CLS_HIGH];
                        stg_class_next       = CLS_HIGH;
                    end else if (!dq_empty[CLS_ORDINARY]) begin
                        dq_cmd[CLS_ORDINARY].pop = 1'b1;
                        out_job_next             = dq_head[CLS_ORDINARY];
                        stg_class_next           = CLS_ORDINARY;
                    end else if (!dq_empty[CLS_LOW]) begin
                        dq_cmd[CLS_LOW].pop = 1'b1;
                        out_job_next        = dq_head[CLS_LOW];
                        stg_class_next      = CLS_LOW;
                    end else begin
                        out_status_next = ST_EMPTY;
                    end
                    if (out_status_next == ST_OK) begin
                        stg_valid_next = 1'b1;
                        stg_id_next    = out_job_next;
                    end
                end
                REQ_RETURN: begin
                    if (!stg_valid_reg) begin
                        out_status_next = ST_EMPTY;
                    end else begin
                        out_job_next = stg_id_reg;
                        if (dq_full[stg_class_reg]) begin
                            out_status_next = ST_FULL;
                        end else begin
                            dq_cmd[stg_class_reg].push    = 1'b1;
                            dq_cmd[stg_class_reg].at_head = in_front_reg;
                            stg_valid_next = 1'b0;
                            stg_id_next    = '0;
                            stg_class_next = CLS_HIGH;
                        end
                    end
                end
                REQ_COMMIT: begin
                    if (!stg_valid_reg) begin
                        out_status_next = ST_EMPTY;
                    end else begin
                        out_job_next   = stg_id_reg;
                        out_run_next   = 1'b1;
                        stg_valid_next = 1'b0;
                        stg_id_next    = '0;
                        stg_class_next = CLS_HIGH;
                    end
                end
                default: begin
                    out_status_next = ST_OK;
                end
            endcase
        end
    end

    // post-request waiting count, saturated, and empty flags
    assign total = TOT_W'(dq_count[CLS_HIGH]) + TOT_W'(dq_count[CLS_ORDINARY])
                 + TOT_W'(dq_count[CLS_LOW]);
    assign out_wait_next = (total > TOT_W'(WAIT_MAX)) ?
                           WAIT_COUNT_W'(WAIT_MAX) : total[WAIT_COUNT_W-1:0];

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            out_empty_next[c] = (dq_count[c] == '0);
        end
    end

    // staging slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            stg_id_reg    <= '0;
            stg_class_reg <= CLS_HIGH;
        end else begin
            stg_valid_reg <= stg_valid_next;
            stg_id_reg    <= stg_id_next;
            stg_class_reg <= stg_class_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_status_reg    <= out_status_next;
            out_job_reg       <= out_job_next;
            out_run_reg       <= out_run_next;
            out_stg_valid_reg <= stg_valid_next;
            out_stg_job_reg   <= stg_valid_next ? stg_id_next : '0;
            out_wait_reg      <= out_wait_next;
            out_empty_reg     <= out_empty_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_result_job     = out_job_reg;
    assign m_run_valid      = out_run_reg;
    assign m_staging_valid  = out_stg_valid_reg;
    assign m_staging_job    = out_stg_job_reg;
    assign m_waiting_count  = out_wait_reg;
    assign m_high_empty     = out_empty_reg[CLS_HIGH];
    assign m_ordinary_empty = out_empty_reg[CLS_ORDINARY];
    assign m_low_empty      = out_empty_reg[CLS_LOW];

endmodule
